>>> sv/tccc_pkg.sv
// shared types, codes and helpers for the text console cursor control block
`default_nettype none

package tccc_pkg;

    // result actions
    localparam logic [1:0] ACT_DRAW        = 2'd0;
    localparam logic [1:0] ACT_SCROLL_UP   = 2'd1;
    localparam logic [1:0] ACT_SCROLL_DOWN = 2'd2;
    localparam logic [1:0] ACT_CLEAR       = 2'd3;

    // character codes with a meaning of their own
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TILDE = 8'd126;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CH_NBSP  = 8'd160;
    localparam logic [7:0] CH_MAX   = 8'hFF;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd2;
    localparam int CFG_DATA_W = 9;

    localparam logic [8:0] GRID_MIN           = 9'd1;
    localparam logic [8:0] GRID_MAX           = 9'd256;
    localparam logic [8:0] GRID_COLUMNS_RESET = 9'd80;
    localparam logic [8:0] GRID_ROWS_RESET    = 9'd25;

    // result queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] glyph_code;
        logic [7:0] draw_row;
        logic [7:0] draw_col;
        logic [7:0] cursor_row_after;
        logic [7:0] cursor_col_after;
        logic       last;
    } t_result;

    // up to two results written into the queue together
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

    function automatic logic [8:0] grid_size(input logic [8:0] v);
        logic [8:0] s;
        if (v < GRID_MIN) begin
            s = GRID_MIN;
        end else if (v > GRID_MAX) begin
            s = GRID_MAX;
        end else begin
            s = v;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

>>> sv/tccc_step.sv
// cursor step logic: decodes one character against the cursor and grid size
`default_nettype none

module tccc_step
    import tccc_pkg::*;
(
    input  wire logic [7:0] i_char_code,
    input  wire logic [7:0] i_cursor_row,
    input  wire logic [7:0] i_cursor_col,
    input  wire logic [8:0] i_grid_columns,
    input  wire logic [8:0] i_grid_rows,
    output t_push           o_push,
    output logic [7:0]      o_cursor_row,
    output logic [7:0]      o_cursor_col
);

    logic [8:0] w_cols_m1;
    logic [8:0] w_rows_m1;
    logic [7:0] w_last_col;
    logic [7:0] w_last_row;
    logic [7:0] w_row;
    logic [7:0] w_col;
    logic [7:0] w_col_dec;
    logic [7:0] w_col_inc;
    logic       w_col_wrap;

    assign w_cols_m1  = grid_size(i_grid_columns) - 9'd1;
    assign w_rows_m1  = grid_size(i_grid_rows) - 9'd1;
    assign w_last_col = w_cols_m1[7:0];
    assign w_last_row = w_rows_m1[7:0];

    // clamp a stale position into the current grid first
    assign w_row = (i_cursor_row > w_last_row) ? w_last_row : i_cursor_row;
    assign w_col = (i_cursor_col > w_last_col) ? w_last_col : i_cursor_col;

    assign w_col_dec  = (w_col == 8'd0) ? w_last_col : w_col - 8'd1;
    assign w_col_wrap = (w_col == w_last_col);
    assign w_col_inc  = w_col_wrap ? 8'd0 : w_col + 8'd1;

    always_comb begin
        t_result    r0;
        t_result    r1;
        logic [1:0] cnt;
        logic [7:0] nrow;
        logic [7:0] ncol;

        r0   = '0;
        r1   = '0;
        cnt  = 2'd0;
        nrow = w_row;
        ncol = w_col;

        unique case (i_char_code) inside
            CH_BS: begin
                ncol = w_col_dec;
                if (w_col == 8'd0) begin
                    if (w_row == 8'd0) begin
                        r0.action = ACT_SCROLL_DOWN;
                        cnt       = 2'd1;
                    end else begin
                        nrow = w_row - 8'd1;
                    end
                end
            end
            CH_DEL: begin
                ncol = w_col_dec;
                if (w_col == 8'd0 && w_row == 8'd0) begin
                    // wrap above the top: scroll first, then blank the cell
                    r0.action     = ACT_SCROLL_DOWN;
                    r1.action     = ACT_DRAW;
                    r1.glyph_code = CH_SPACE;
                    r1.draw_row   = 8'd0;
                    r1.draw_col   = w_col_dec;
                    cnt           = 2'd2;
                end else begin
                    if (w_col == 8'd0) begin
                        nrow = w_row - 8'd1;
                    end
                    r0.action     = ACT_DRAW;
                    r0.glyph_code = CH_SPACE;
                    r0.draw_row   = nrow;
                    r0.draw_col   = w_col_dec;
                    cnt           = 2'd1;
                end
            end
            CH_TAB: begin
                ncol = w_col_inc;
                if (w_col_wrap) begin
                    if (w_row == w_last_row) begin
                        r0.action = ACT_SCROLL_UP;
                        cnt       = 2'd1;
                    end else begin
                        nrow = w_row + 8'd1;
                    end
                end
            end
            CH_LF: begin
                if (w_row == w_last_row) begin
                    r0.action = ACT_SCROLL_UP;
                    cnt       = 2'd1;
                end else begin
                    nrow = w_row + 8'd1;
                end
            end
            CH_VT: begin
                if (w_row == 8'd0) begin
                    r0.action = ACT_SCROLL_DOWN;
                    cnt       = 2'd1;
                end else begin
                    nrow = w_row - 8'd1;
                end
            end
            CH_FF: begin
                r0.action = ACT_CLEAR;
                cnt       = 2'd1;
                nrow      = 8'd0;
                ncol      = 8'd0;
            end
            CH_CR: begin
                ncol = 8'd0;
            end
            [CH_SPACE:CH_TILDE], [CH_NBSP:CH_MAX]: begin
                r0.action     = ACT_DRAW;
                r0.glyph_code = i_char_code;
                r0.draw_row   = w_row;
                r0.draw_col   = w_col;
                cnt           = 2'd1;
                ncol          = w_col_inc;
                if (w_col_wrap) begin
                    if (w_row == w_last_row) begin
                        r1.action = ACT_SCROLL_UP;
                        cnt       = 2'd2;
                    end else begin
                        nrow = w_row + 8'd1;
                    end
                end
            end
            default: begin
                // other codes only store the clamped position
            end
        endcase

        r0.cursor_row_after = nrow;
        r0.cursor_col_after = ncol;
        r0.last             = (cnt == 2'd1);
        r1.cursor_row_after = nrow;
        r1.cursor_col_after = ncol;
        r1.last             = 1'b1;

        o_push.count = cnt;
        o_push.res0  = r0;
        o_push.res1  = r1;
        o_cursor_row = nrow;
        o_cursor_col = ncol;
    end

endmodule

`default_nettype wire

>>> sv/tccc_result_queue.sv
// result queue: takes up to two results a cycle, hands out one a cycle unless stalled
`default_nettype none

module tccc_result_queue
    import tccc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_push i_push,
    output logic      o_room,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_result   o_result
);

    t_result          r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] w_wr_ptr1;
    logic             w_pop;
    logic [CNT_W-1:0] n_count;

    assign w_wr_ptr1 = r_wr_ptr + PTR_W'(1);
    assign w_pop     = o_valid && !i_stall;
    assign n_count   = r_count + CNT_W'(i_push.count) - CNT_W'(w_pop);

    // room for a full pair of results
    assign o_room   = (r_count <= CNT_W'(QUEUE_DEPTH - 2));
    assign o_valid  = (r_count != '0);
    assign o_result = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[w_wr_ptr1] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(i_push.count);
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

>>> sv/text_console_cursor_control_core.sv
// top level of the text console cursor control block
`default_nettype none

// One character request is taken per clock while o_in_stall is low. It is
// held in an input register, decoded against the cursor and the grid size,
// and its zero, one or two results go into a four-entry result queue that
// hands out one result per clock while i_out_stall is low; the first result
// of a request passes through the input register and then the result queue.
// A request that produces two results needs the output port for both, so
// the output port of the result queue sets the sustained rate: one request
// per clock for single-result traffic, fewer when requests yield two
// results. Configuration writes are accepted at once and should only be
// made while the block is idle. The block needs no clearing pass after reset.

module text_console_cursor_control_core
    import tccc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [7:0]            i_in_char_code,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [1:0]                 o_action,
    output logic [7:0]                 o_glyph_code,
    output logic [7:0]                 o_draw_row,
    output logic [7:0]                 o_draw_col,
    output logic [7:0]                 o_cursor_row_after,
    output logic [7:0]                 o_cursor_col_after,
    output logic                       o_last
);

    logic       r_enabled;
    logic [8:0] r_grid_columns;
    logic [8:0] r_grid_rows;
    logic [7:0] r_cursor_row;
    logic [7:0] r_cursor_col;
    logic       r_in_valid;
    logic [7:0] r_in_char;

    t_push      w_step_push;
    t_push      w_push;
    logic [7:0] w_next_row;
    logic [7:0] w_next_col;
    logic       w_room;
    logic       w_advance;
    t_result    w_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled      <= 1'b0;
            r_grid_columns <= GRID_COLUMNS_RESET;
            r_grid_rows    <= GRID_ROWS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ENABLE:  r_enabled      <= i_cfg_data[0];
                CFG_COLUMNS: r_grid_columns <= i_cfg_data;
                CFG_ROWS:    r_grid_rows    <= i_cfg_data;
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // input register moves on whenever the queue can take a full pair
    assign w_advance  = r_in_valid && w_room;
    assign o_in_stall = r_in_valid && !w_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_char <= i_in_char_code;
        end
    end

    tccc_step u_step (
        .i_char_code    (r_in_char),
        .i_cursor_row   (r_cursor_row),
        .i_cursor_col   (r_cursor_col),
        .i_grid_columns (r_grid_columns),
        .i_grid_rows    (r_grid_rows),
        .o_push         (w_step_push),
        .o_cursor_row   (w_next_row),
        .o_cursor_col   (w_next_col)
    );

    // a disabled console swallows the request without trace
    always_comb begin
        w_push = w_step_push;
        if (!(w_advance && r_enabled)) begin
            w_push.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_row <= 8'd0;
            r_cursor_col <= 8'd0;
        end else if (w_advance && r_enabled) begin
            r_cursor_row <= w_next_row;
            r_cursor_col <= w_next_col;
        end
    end

    tccc_result_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .o_room   (w_room),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (w_result)
    );

    assign o_action           = w_result.action;
    assign o_glyph_code       = w_result.glyph_code;
    assign o_draw_row         = w_result.draw_row;
    assign o_draw_col         = w_result.draw_col;
    assign o_cursor_row_after = w_result.cursor_row_after;
    assign o_cursor_col_after = w_result.cursor_col_after;
    assign o_last             = w_result.last;

endmodule

`default_nettype wire

>>> sv/tccc_checker.sv
// port-level checks for the text console cursor control block, with bind
`default_nettype none

module tccc_checker
    import tccc_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [1:0] o_action,
    input wire logic [7:0] o_glyph_code,
    input wire logic [7:0] o_draw_row,
    input wire logic [7:0] o_draw_col,
    input wire logic [7:0] o_cursor_row_after,
    input wire logic [7:0] o_cursor_col_after,
    input wire logic       o_last
);

    // results other than a draw carry no cell or glyph
    a_non_draw_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_action != ACT_DRAW) |->
            (o_glyph_code == 8'd0 && o_draw_row == 8'd0 && o_draw_col == 8'd0))
        else $error("non-draw result carries cell or glyph");

    // clearing homes the cursor and ends its request
    a_clear_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_action == ACT_CLEAR) |->
            (o_cursor_row_after == 8'd0 && o_cursor_col_after == 8'd0 && o_last))
        else $error("clear result without home cursor or last");

    // the second result of a pair is queued along with the first
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last) |=> o_out_valid)
        else $error("first result of a pair not followed by the second");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_action) && $stable(o_glyph_code)
             && $stable(o_draw_row) && $stable(o_draw_col)
             && $stable(o_cursor_row_after) && $stable(o_cursor_col_after)
             && $stable(o_last)))
        else $error("stalled result changed");

endmodule

bind text_console_cursor_control_core tccc_checker u_tccc_checker (.*);

`default_nettype wire
